>>> rtl/kvcf_pkg.sv
package kvcf_pkg;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int DEPTH_DEF   = 64;
    localparam int MAX_RESULTS = 32;
    localparam int NQ_W        = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_rec;

endpackage

>>> rtl/kvcf_rec_if.sv
interface kvcf_rec_if
    import kvcf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] rec_key;
    logic [VAL_W-1:0] rec_value;
    logic             last_record;

    modport source (output valid, output rec_key, output rec_value, output last_record,
                    input ready);
    modport sink   (input valid, input rec_key, input rec_value, input last_record,
                    output ready);
endinterface

>>> rtl/kvcf_res_if.sv
interface kvcf_res_if
    import kvcf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] conflict_key;
    logic             found;
    logic             overflow;
    logic             last_result;

    modport source (output valid, output conflict_key, output found, output overflow,
                    output last_result, input ready);
    modport sink   (input valid, input conflict_key, input found, input overflow,
                    input last_result, output ready);
endinterface

>>> rtl/key_value_conflict_finder_unit.sv
// channel | dir | modport | payload
// i_rec   | in  | sink    | rec_key[31:0], rec_value[31:0], last_record
// o_res   | out | source  | conflict_key[31:0], found, overflow, last_result
//
// Records load at one per cycle into the record store while ready is high.
// After the final record, an insertion sort orders the stored records by key (SRD, SGET, SCHK,
// SCMP), then a scan (QRD, QCMP) reports each key whose records hold differing values.
// Ready stays low from the final record until the last result enters the output register.
// Synchronous active-low reset clears the state, the record and result counts, flags and output valid.
// A stalled output holds the scan when a result is due; the output register frees the input side.
module key_value_conflict_finder_unit
    import kvcf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kvcf_rec_if.sink   i_rec,
    kvcf_res_if.source o_res
);

    localparam int AW = $clog2(DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_rec          mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_rec          mem_rdata;

    kvcf_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    kvcf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (i_rec),
        .o_res       (o_res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

endmodule

>>> rtl/kvcf_store.sv
module kvcf_store
    import kvcf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_rec          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_rec          o_rdata
);

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/kvcf_ctrl.sv
module kvcf_ctrl
    import kvcf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kvcf_rec_if.sink      i_rec,
    kvcf_res_if.source    o_res,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output t_rec          o_mem_wdata,
    output logic [AW-1:0] o_mem_raddr,
    input  t_rec          i_mem_rdata
);

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_SRD  = 4'd1;
    localparam logic [3:0] S_SGET = 4'd2;
    localparam logic [3:0] S_SCHK = 4'd3;
    localparam logic [3:0] S_SCMP = 4'd4;
    localparam logic [3:0] S_QRD  = 4'd5;
    localparam logic [3:0] S_QCMP = 4'd6;
    localparam logic [3:0] S_QEND = 4'd7;
    localparam logic [3:0] S_QFIN = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [CW-1:0]    r_i, n_i;
    logic [AW-1:0]    r_j, n_j;
    t_rec             r_cur, n_cur;
    logic [CW-1:0]    r_t, n_t;
    logic             r_have, n_have;
    logic [KEY_W-1:0] r_gkey, n_gkey;
    logic [VAL_W-1:0] r_gval, n_gval;
    logic             r_diff, n_diff;
    logic             r_pend, n_pend;
    logic [KEY_W-1:0] r_pkey, n_pkey;
    logic [NQ_W-1:0]  r_nq, n_nq;

    logic             r_out_valid;
    logic [KEY_W-1:0] r_out_key;
    logic             r_out_found;
    logic             r_out_ovf;
    logic             r_out_last;

    logic             push;
    logic [KEY_W-1:0] push_key;
    logic             push_found;
    logic             push_last;
    logic             out_free;
    logic             key_gt;
    logic             key_eq;
    logic             qual;

    assign out_free = !r_out_valid || o_res.ready;
    assign key_gt   = i_mem_rdata.key > r_cur.key;
    assign key_eq   = r_have && (i_mem_rdata.key == r_gkey);
    assign qual     = r_have && r_diff && (r_nq < NQ_W'(MAX_RESULTS));

    assign i_rec.ready = (r_state == S_LOAD);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_cur       = r_cur;
        n_t         = r_t;
        n_have      = r_have;
        n_gkey      = r_gkey;
        n_gval      = r_gval;
        n_diff      = r_diff;
        n_pend      = r_pend;
        n_pkey      = r_pkey;
        n_nq        = r_nq;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_j;
        o_mem_wdata = r_cur;
        o_mem_raddr = r_t[AW-1:0];
        push        = 1'b0;
        push_key    = r_pkey;
        push_found  = 1'b1;
        push_last   = 1'b0;

        case (r_state)
            S_LOAD: begin
                o_mem_waddr = r_count[AW-1:0];
                o_mem_wdata = t_rec'{key: i_rec.rec_key, value: i_rec.rec_value};
                if (i_rec.valid) begin
                    if (r_count < CW'(DEPTH)) begin
                        o_mem_we = 1'b1;
                        n_count  = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_rec.last_record) begin
                        n_i     = CW'(1);
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD: begin
                o_mem_raddr = r_i[AW-1:0];
                if (r_i >= r_count) begin
                    n_t     = '0;
                    n_have  = 1'b0;
                    n_diff  = 1'b0;
                    n_pend  = 1'b0;
                    n_nq    = '0;
                    n_state = S_QRD;
                end else begin
                    n_state = S_SGET;
                end
            end
            S_SGET: begin
                n_cur   = i_mem_rdata;
                n_j     = r_i[AW-1:0];
                n_state = S_SCHK;
            end
            S_SCHK: begin
                o_mem_raddr = r_j - AW'(1);
                if (r_j == '0) begin
                    o_mem_we = 1'b1;
                    n_i      = r_i + CW'(1);
                    n_state  = S_SRD;
                end else begin
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                o_mem_we = 1'b1;
                if (key_gt) begin
                    o_mem_wdata = i_mem_rdata;
                    n_j         = r_j - AW'(1);
                    n_state     = S_SCHK;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_SRD;
                end
            end
            S_QRD: begin
                if (r_t >= r_count) begin
                    n_state = S_QEND;
                end else begin
                    n_state = S_QCMP;
                end
            end
            S_QCMP: begin
                if (key_eq) begin
                    if (i_mem_rdata.value != r_gval) begin
                        n_diff = 1'b1;
                    end
                    n_t     = r_t + CW'(1);
                    n_state = S_QRD;
                end else if (!(qual && r_pend && !out_free)) begin
                    if (qual) begin
                        push   = r_pend;
                        n_pend = 1'b1;
                        n_pkey = r_gkey;
                        n_nq   = r_nq + NQ_W'(1);
                    end
                    n_have  = 1'b1;
                    n_gkey  = i_mem_rdata.key;
                    n_gval  = i_mem_rdata.value;
                    n_diff  = 1'b0;
                    n_t     = r_t + CW'(1);
                    n_state = S_QRD;
                end
            end
            S_QEND: begin
                if (qual) begin
                    if (!(r_pend && !out_free)) begin
                        push   = r_pend;
                        n_pend = 1'b1;
                        n_pkey = r_gkey;
                        n_nq   = r_nq + NQ_W'(1);
                        n_have = 1'b0;
                    end
                end else begin
                    n_state = S_QFIN;
                end
            end
            S_QFIN: begin
                if (out_free) begin
                    push       = 1'b1;
                    push_key   = r_pend ? r_pkey : '0;
                    push_found = r_pend;
                    push_last  = 1'b1;
                    n_count    = '0;
                    n_ovf      = 1'b0;
                    n_have     = 1'b0;
                    n_pend     = 1'b0;
                    n_nq       = '0;
                    n_state    = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_have      <= 1'b0;
            r_diff      <= 1'b0;
            r_pend      <= 1'b0;
            r_nq        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_have  <= n_have;
            r_diff  <= n_diff;
            r_pend  <= n_pend;
            r_nq    <= n_nq;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_cur  <= n_cur;
        r_t    <= n_t;
        r_gkey <= n_gkey;
        r_gval <= n_gval;
        r_pkey <= n_pkey;
        if (push) begin
            r_out_key   <= push_key;
            r_out_found <= push_found;
            r_out_ovf   <= r_ovf;
            r_out_last  <= push_last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.conflict_key = r_out_key;
    assign o_res.found        = r_out_found;
    assign o_res.overflow     = r_out_ovf;
    assign o_res.last_result  = r_out_last;

endmodule
